@@ hdl/escape_rle_decoder_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the escape run-length decoder
// Short wrappers that clock every check on clk and hold it off during reset.
// ---------------------------------------------------------------------------
`ifndef ESCAPE_RLE_DECODER_UNIT_ASSERT_SVH
`define ESCAPE_RLE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ERD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("erd assertion failed");

// Next-cycle implication.
`define ERD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("erd assertion failed");

`endif

@@ hdl/erd_pkg.sv @@
// ---------------------------------------------------------------------------
// erd_pkg
// Shared widths, register addresses and the decode phase type.
// ---------------------------------------------------------------------------
package erd_pkg;

  localparam int BYTE_W = 8;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Word select bit of paddr: byte address 0 and 4.
  localparam logic REG_MARK_BYTE = 1'b0;
  localparam logic REG_COUNT_OFFSET = 1'b1;

  localparam logic [BYTE_W-1:0] MARK_BYTE_RST = 8'd42;
  localparam logic [BYTE_W-1:0] COUNT_OFFSET_RST = 8'd48;

  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [2:0] {
    PH_LITERAL = 3'b001,
    PH_COUNT   = 3'b010,
    PH_VALUE   = 3'b100
  } erd_phase_t;

endpackage

@@ hdl/escape_rle_decoder_unit.sv @@
// Path: a literal or the first copy of a run is written into the command queue when its
// input word is accepted, and is loaded from there into the output register as the expander advances.
// Throughput: one input word per cycle while literals flow and the output is popped; a
// run holds the expander until its last copy is loaded. Input stalls once the two-entry
// command queue fills. Reset: synchronous, active low; clears the phase, pending count,
// queue and output, and restores the mark and offset registers.
// ---------------------------------------------------------------------------
// escape_rle_decoder_unit
// Escape-marker run-length decoder with an APB-style register port.
// ---------------------------------------------------------------------------
`include "escape_rle_decoder_unit_assert.svh"

module escape_rle_decoder_unit #(
  parameter int MAX_RUN = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input byte stream, queue-style write side.
  input  logic                         push,
  input  logic [erd_pkg::BYTE_W-1:0]   in_byte,
  output logic                         full,
  // Decompressed stream, queue-style read side.
  input  logic                         pop,
  output logic                         empty,
  output logic [erd_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_run_last,
  // Register port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [erd_pkg::PADDR_W-1:0]  paddr,
  input  logic [erd_pkg::PDATA_W-1:0]  pwdata,
  output logic [erd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  // Width of a repeat count, wide enough to hold MAX_RUN itself.
  localparam int CNT_W = $clog2(MAX_RUN + 1);
  localparam int CMD_W = erd_pkg::BYTE_W + CNT_W;

  logic [erd_pkg::BYTE_W-1:0] mark_byte_r;
  logic [erd_pkg::BYTE_W-1:0] count_offset_r;
  logic                       cfg_wr;

  logic             q_push, q_full, q_pop, q_empty;
  logic [CMD_W-1:0] q_wdata, q_rdata;

  // Registers are addressed by word; paddr[2] picks the register, so every
  // write lands in one of the two.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_byte_r    <= erd_pkg::MARK_BYTE_RST;
      count_offset_r <= erd_pkg::COUNT_OFFSET_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == erd_pkg::REG_MARK_BYTE) begin
        mark_byte_r <= pwdata[erd_pkg::BYTE_W-1:0];
      end else begin
        count_offset_r <= pwdata[erd_pkg::BYTE_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      erd_pkg::REG_MARK_BYTE:
        prdata = {{(erd_pkg::PDATA_W-erd_pkg::BYTE_W){1'b0}}, mark_byte_r};
      erd_pkg::REG_COUNT_OFFSET:
        prdata = {{(erd_pkg::PDATA_W-erd_pkg::BYTE_W){1'b0}}, count_offset_r};
      default:
        prdata = '0;
    endcase
  end

  // The classifier tracks the escape phase and turns each byte into at most
  // one command: a literal becomes a run of one, a value byte becomes a run
  // of the saturated count. Marks, counts and empty runs queue nothing.
  erd_front #(
    .MAX_RUN (MAX_RUN),
    .CNT_W   (CNT_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (push),
    .in_byte      (in_byte),
    .in_full      (full),
    .mark_byte    (mark_byte_r),
    .count_offset (count_offset_r),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_full       (q_full)
  );

  erd_cmd_fifo #(
    .W (CMD_W)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // The expander repeats the value of the head command once per cycle while the output
  // is popped and flags the final copy; its output register lets it start the next word
  // in the same cycle the waiting one is taken.
  erd_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .out_pop      (pop),
    .out_empty    (empty),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

  // The classifier must never write a command into a full queue.
  `ERD_ASSERT_SAME(a_no_q_overflow, q_push, !q_full)
  // The expander reads only a queue that holds a command.
  `ERD_ASSERT_SAME(a_no_q_underflow, q_pop, !q_empty)
  // Once a run has started, its remaining copies follow without a gap.
  `ERD_ASSERT_NEXT(a_run_continues, pop && !empty && !out_run_last, !empty)

endmodule

@@ hdl/erd_cmd_fifo.sv @@
// ---------------------------------------------------------------------------
// erd_cmd_fifo
// Short command queue between the classifier and the run expander.
// ---------------------------------------------------------------------------
module erd_cmd_fifo #(
  parameter int W = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PTR_W = $clog2(erd_pkg::CMDQ_DEPTH);
  localparam int CNT_W = $clog2(erd_pkg::CMDQ_DEPTH + 1);

  logic [W-1:0]     mem_r [erd_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(erd_pkg::CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(erd_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(erd_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hdl/erd_front.sv @@
// ---------------------------------------------------------------------------
// erd_front
// Classifies each input byte as literal, mark, count or value and queues
// a (value, count) command for every byte that produces output.
// ---------------------------------------------------------------------------
module erd_front #(
  parameter int MAX_RUN = 64,
  parameter int CNT_W   = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  logic [erd_pkg::BYTE_W-1:0]  in_byte,
  output logic                        in_full,
  input  logic [erd_pkg::BYTE_W-1:0]  mark_byte,
  input  logic [erd_pkg::BYTE_W-1:0]  count_offset,
  output logic                        q_push,
  output logic [erd_pkg::BYTE_W+CNT_W-1:0] q_data,
  input  logic                        q_full
);

  erd_pkg::erd_phase_t        phase_r, phase_nxt;
  logic [CNT_W-1:0]           pend_r, pend_nxt;
  logic [erd_pkg::BYTE_W:0]   diff;
  logic                       accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    q_push    = 1'b0;
    q_data    = {in_byte, CNT_W'(1)};
    // Signed difference: the extra top bit is the borrow.
    diff = {1'b0, in_byte} - {1'b0, count_offset};
    if (accept) begin
      unique case (phase_r)
        erd_pkg::PH_COUNT: begin
          phase_nxt = erd_pkg::PH_VALUE;
          if (diff[erd_pkg::BYTE_W] || (diff == '0)) begin
            pend_nxt = '0;
          end else if (diff > (erd_pkg::BYTE_W+1)'(MAX_RUN)) begin
            pend_nxt = CNT_W'(MAX_RUN);
          end else begin
            pend_nxt = diff[CNT_W-1:0];
          end
        end
        erd_pkg::PH_VALUE: begin
          phase_nxt = erd_pkg::PH_LITERAL;
          pend_nxt  = '0;
          // A run of zero copies is simply dropped here.
          if (pend_r != '0) begin
            q_push = 1'b1;
            q_data = {in_byte, pend_r};
          end
        end
        default: begin
          phase_nxt = erd_pkg::PH_LITERAL;
          if (in_byte == mark_byte) begin
            phase_nxt = erd_pkg::PH_COUNT;
          end else begin
            q_push = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= erd_pkg::PH_LITERAL;
      pend_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

@@ hdl/erd_back.sv @@
// ---------------------------------------------------------------------------
// erd_back
// Expands queued commands into output words, one copy per cycle while the output is
// popped, through a registered output stage.
// ---------------------------------------------------------------------------
module erd_back #(
  parameter int CNT_W = 7
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  logic [erd_pkg::BYTE_W+CNT_W-1:0] q_data,
  output logic                             q_pop,
  input  logic                             out_pop,
  output logic                             out_empty,
  output logic [erd_pkg::BYTE_W-1:0]       out_byte,
  output logic                             out_run_last
);

  logic                        busy_r, busy_nxt;
  logic [CNT_W-1:0]            rem_r, rem_nxt;
  logic [erd_pkg::BYTE_W-1:0]  val_r, val_nxt;
  logic                        ov_r, ov_nxt;
  logic [erd_pkg::BYTE_W-1:0]  ob_r, ob_nxt;
  logic                        ol_r, ol_nxt;
  logic                        advance;
  logic [CNT_W-1:0]            q_cnt;
  logic [erd_pkg::BYTE_W-1:0]  q_val;

  assign q_cnt   = q_data[CNT_W-1:0];
  assign q_val   = q_data[erd_pkg::BYTE_W+CNT_W-1:CNT_W];
  assign advance = !ov_r || out_pop;

  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    val_nxt  = val_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;
    ol_nxt   = ol_r;
    q_pop    = 1'b0;
    if (advance) begin
      if (busy_r) begin
        ov_nxt   = 1'b1;
        ob_nxt   = val_r;
        ol_nxt   = (rem_r == CNT_W'(1));
        rem_nxt  = rem_r - 1'b1;
        busy_nxt = (rem_r != CNT_W'(1));
      end else if (!q_empty) begin
        q_pop    = 1'b1;
        ov_nxt   = 1'b1;
        ob_nxt   = q_val;
        ol_nxt   = (q_cnt == CNT_W'(1));
        val_nxt  = q_val;
        rem_nxt  = q_cnt - 1'b1;
        busy_nxt = (q_cnt != CNT_W'(1));
      end else begin
        ov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      rem_r  <= rem_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_empty    = !ov_r;
  assign out_byte     = ob_r;
  assign out_run_last = ol_r;

endmodule
